[hdl/cau_pkg.sv]
package cau_pkg;

	localparam int REQ_W = 3;
	localparam int ST_W  = 2;

	localparam logic [REQ_W-1:0] OP_ADD   = 3'd0;
	localparam logic [REQ_W-1:0] OP_SUB   = 3'd1;
	localparam logic [REQ_W-1:0] OP_MUL   = 3'd2;
	localparam logic [REQ_W-1:0] OP_DIV   = 3'd3;
	localparam logic [REQ_W-1:0] OP_CONJ  = 3'd4;
	localparam logic [REQ_W-1:0] OP_MAG   = 3'd5;
	localparam logic [REQ_W-1:0] OP_PHASE = 3'd6;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
	localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

	// CORDIC vectoring: angle accumulator in Q30, datapath sized for operands
	// normalized to the 2^40 range plus the CORDIC gain.
	localparam int ANG_FRAC     = 30;
	localparam int CORDIC_STEPS = 31;
	localparam int NORM_EXP     = 40;
	localparam int CW           = 48;
	localparam int ZW           = 33;
	localparam int KW           = $clog2(NORM_EXP + 1);

	function automatic logic signed [ZW-1:0] cordic_angle(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = ZW'(64'sd843314857);
			1: a = ZW'(64'sd497837829);
			2: a = ZW'(64'sd263043837);
			3: a = ZW'(64'sd133525159);
			4: a = ZW'(64'sd67021687);
			5: a = ZW'(64'sd33543516);
			6: a = ZW'(64'sd16775851);
			7: a = ZW'(64'sd8388437);
			8: a = ZW'(64'sd4194283);
			9: a = ZW'(64'sd2097149);
			default: begin
				if (i <= ANG_FRAC) begin
					a = ZW'(1) << (ANG_FRAC - i);
				end else begin
					a = '0;
				end
			end
		endcase
		return a;
	endfunction

endpackage

[hdl/complex_arithmetic_unit.sv]
// Complex arithmetic unit, fully pipelined.
// Input channel s_axis: tuser carries the opcode, tdata the operands a and b.
// Output channel m_axis: tdata carries the complex result, tuser the status
// (ok, saturated, division by zero).
// Opcodes: add, subtract, multiply, divide, conjugate, magnitude and phase.
// The chain of iteration stages, NSTEP = max(WIDTH + FRAC_BITS + 1, 31),
// is set by the longer of the bit-per-stage divider and the 31-step CORDIC;
// the square root shares the same stages.
// One word is accepted every cycle while the output is taken.
// Every stage has its own valid bit and holds only when the next stage is
// full and holding, so a stalled receiver freezes the words behind the
// result while bubbles further up still close and input keeps flowing until
// the pipeline is full. Nothing is dropped or repeated.
// Reset clears all valid bits; the block is ready in the first cycle after.
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// a_re, a_im, b_re, b_im, zero fill
	input  logic [((4*WIDTH+7)/8)*8-1:0]          s_axis_tdata,
	// req_type
	input  logic [REQ_W-1:0]                     s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// out_re, out_im, zero fill
	output logic [((2*WIDTH+7)/8)*8-1:0]          m_axis_tdata,
	// status
	output logic [ST_W-1:0]                      m_axis_tuser
);

	localparam int W      = WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int PW     = 2 * W;
	localparam int D      = W + F + 1;
	localparam int NSTEP  = (D > CORDIC_STEPS) ? D : CORDIC_STEPS;
	localparam int OUT_DW = ((2*WIDTH+7)/8)*8;
	localparam int PEW    = $clog2(W + 1);
	localparam int ZSH    = ANG_FRAC - F;
	localparam int SW0    = (PW + 1 > D + 1) ? PW + 1 : D + 1;
	localparam int SW     = (SW0 > ZW + 1) ? SW0 : ZW + 1;

	// Saturate a sign and magnitude pair; the top bit of the result flags it.
	function automatic logic [W:0] settle(input logic neg, input logic [SW-1:0] mag);
		logic [SW-1:0] lim;
		logic [SW-1:0] m;
		logic          sat;
		lim = (SW'(1) << (W - 1)) - (neg ? SW'(0) : SW'(1));
		sat = mag > lim;
		m   = sat ? lim : mag;
		return {sat, neg ? -m[W-1:0] : m[W-1:0]};
	endfunction

	function automatic logic [W:0] clamp(input logic signed [W:0] v);
		logic sat;
		sat = v[W] ^ v[W-1];
		return {sat, sat ? {v[W], {(W-1){~v[W]}}} : v[W-1:0]};
	endfunction

	function automatic logic [PEW-1:0] msb_pos(input logic [W:0] m);
		logic [PEW-1:0] p;
		p = '0;
		for (int i = 0; i <= W; i++) begin
			if (m[i]) begin
				p = PEW'(i);
			end
		end
		return p;
	endfunction

	// ---------------- handshake ----------------
	logic v_s1, v_s2, v_s3;
	logic v_s [0:NSTEP];
	logic en_s1, en_s2, en_s3, en_o;
	logic en_s [0:NSTEP];
	logic ovld_q;

	assign en_o  = !ovld_q || m_axis_tready;
	assign en_s[NSTEP] = !v_s[NSTEP] || en_o;
	for (genvar k = 0; k < NSTEP; k++) begin : g_en
		assign en_s[k] = !v_s[k] || en_s[k+1];
	end
	assign en_s3 = !v_s3 || en_s[0];
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s[0] <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s[0]) v_s[0] <= v_s3;
			if (en_o) ovld_q <= v_s[NSTEP];
		end
	end

	// ---------------- stage 1: input register ----------------
	logic [REQ_W-1:0]    op_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1 <= s_axis_tuser;
			ar_s1 <= s_axis_tdata[W-1:0];
			ai_s1 <= s_axis_tdata[2*W-1:W];
			br_s1 <= s_axis_tdata[3*W-1:2*W];
			bi_s1 <= s_axis_tdata[4*W-1:3*W];
		end
	end

	// ---------------- stage 2: products, simple ops ----------------
	logic signed [W-1:0] mr, mi;
	logic [W:0]          c_re, c_im;
	logic [W-1:0]        smp_re, smp_im;
	logic [ST_W-1:0]     smp_st;

	assign mr = (op_s1 == OP_MAG) ? ar_s1 : br_s1;
	assign mi = (op_s1 == OP_MAG) ? ai_s1 : bi_s1;

	always_comb begin
		c_re   = '0;
		c_im   = '0;
		smp_re = '0;
		smp_im = '0;
		smp_st = ST_OK;
		case (op_s1)
			OP_ADD: begin
				c_re = clamp((W+1)'(ar_s1) + (W+1)'(br_s1));
				c_im = clamp((W+1)'(ai_s1) + (W+1)'(bi_s1));
			end
			OP_SUB: begin
				c_re = clamp((W+1)'(ar_s1) - (W+1)'(br_s1));
				c_im = clamp((W+1)'(ai_s1) - (W+1)'(bi_s1));
			end
			OP_CONJ: begin
				c_re = {1'b0, ar_s1};
				c_im = clamp(-(W+1)'(ai_s1));
			end
			default: begin
				c_re = '0;
				c_im = '0;
			end
		endcase
		smp_re = c_re[W-1:0];
		smp_im = c_im[W-1:0];
		smp_st = (c_re[W] || c_im[W]) ? ST_SAT : ST_OK;
	end

	logic [REQ_W-1:0]     op_s2;
	logic signed [PW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sqr_s2, sqi_s2;
	logic [W-1:0]         sre_s2, sim_s2;
	logic [ST_W-1:0]      sst_s2;
	logic signed [W:0]    cx_s2, cy_s2;
	logic                 zf_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2  <= op_s1;
			prr_s2 <= ar_s1 * br_s1;
			pii_s2 <= ai_s1 * bi_s1;
			pri_s2 <= ar_s1 * bi_s1;
			pir_s2 <= ai_s1 * br_s1;
			sqr_s2 <= mr * mr;
			sqi_s2 <= mi * mi;
			sre_s2 <= smp_re;
			sim_s2 <= smp_im;
			sst_s2 <= smp_st;
			// The phase runs on the vector folded into the right half plane.
			cx_s2  <= ar_s1[W-1] ? -(W+1)'(ar_s1) : (W+1)'(ar_s1);
			cy_s2  <= ar_s1[W-1] ? -(W+1)'(ai_s1) : (W+1)'(ai_s1);
			zf_s2  <= (ar_s1 == '0);
		end
	end

	// ---------------- stage 3: sums, normalize count ----------------
	logic signed [PW:0] num_re, num_im;
	logic [PW:0]        abs_re, abs_im;
	logic [W:0]         ay;

	always_comb begin
		if (op_s2 == OP_DIV) begin
			num_re = (PW+1)'(prr_s2) + (PW+1)'(pii_s2);
			num_im = (PW+1)'(pir_s2) - (PW+1)'(pri_s2);
		end else begin
			num_re = (PW+1)'(prr_s2) - (PW+1)'(pii_s2);
			num_im = (PW+1)'(pri_s2) + (PW+1)'(pir_s2);
		end
		abs_re = num_re[PW] ? -num_re : num_re;
		abs_im = num_im[PW] ? -num_im : num_im;
	end

	assign ay = cy_s2[W] ? -cy_s2 : cy_s2;

	logic [REQ_W-1:0]  op_s3;
	logic              neg_re_s3, neg_im_s3;
	logic [PW-1:0]     mag_re_s3, mag_im_s3, den_s3;
	logic [W-1:0]      sre_s3, sim_s3;
	logic [ST_W-1:0]   sst_s3;
	logic signed [W:0] cx_s3, cy_s3;
	logic [KW-1:0]     k_s3;
	logic              zf_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3     <= op_s2;
			neg_re_s3 <= num_re[PW];
			neg_im_s3 <= num_im[PW];
			mag_re_s3 <= abs_re[PW-1:0];
			mag_im_s3 <= abs_im[PW-1:0];
			den_s3    <= $unsigned(sqr_s2) + $unsigned(sqi_s2);
			sre_s3    <= sre_s2;
			sim_s3    <= sim_s2;
			sst_s3    <= sst_s2;
			cx_s3     <= cx_s2;
			cy_s3     <= cy_s2;
			k_s3      <= KW'(NORM_EXP) - KW'(msb_pos($unsigned(cx_s2) | ay));
			zf_s3     <= zf_s2;
		end
	end

	// ---------------- stage 4: multiply rounding, iteration setup ----------------
	logic [PW:0] rnd_re, rnd_im;
	logic [W:0]  mul_re, mul_im;

	assign rnd_re = ({1'b0, mag_re_s3} + (PW+1)'(1 << (F - 1))) >> F;
	assign rnd_im = ({1'b0, mag_im_s3} + (PW+1)'(1 << (F - 1))) >> F;
	assign mul_re = settle(neg_re_s3, SW'(rnd_re));
	assign mul_im = settle(neg_im_s3, SW'(rnd_im));

	// Index 0 is stage 4; index k+1 holds the state after iteration k.
	logic [REQ_W-1:0]     op_s    [0:NSTEP];
	logic [W-1:0]         sre_s   [0:NSTEP];
	logic [W-1:0]         sim_s   [0:NSTEP];
	logic [ST_W-1:0]      sst_s   [0:NSTEP];
	logic                 zf_s    [0:NSTEP];
	logic                 neg_re_s[0:NSTEP];
	logic                 neg_im_s[0:NSTEP];
	logic                 ovf_re_s[0:NSTEP];
	logic                 ovf_im_s[0:NSTEP];
	logic [PW-1:0]        den_s   [0:NSTEP];
	logic [PW-1:0]        rem_re_s[0:NSTEP];
	logic [D-1:0]         lo_re_s [0:NSTEP];
	logic [D-1:0]         q_re_s  [0:NSTEP];
	logic [PW-1:0]        rem_im_s[0:NSTEP];
	logic [D-1:0]         lo_im_s [0:NSTEP];
	logic [D-1:0]         q_im_s  [0:NSTEP];
	logic [PW-1:0]        sqn_s   [0:NSTEP];
	logic [PW-1:0]        sqr_s   [0:NSTEP];
	logic signed [CW-1:0] cx_s    [0:NSTEP];
	logic signed [CW-1:0] cy_s    [0:NSTEP];
	logic signed [ZW-1:0] cz_s    [0:NSTEP];

	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			op_s[0]     <= op_s3;
			if (op_s3 == OP_MUL) begin
				sre_s[0] <= mul_re[W-1:0];
				sim_s[0] <= mul_im[W-1:0];
				sst_s[0] <= (mul_re[W] || mul_im[W]) ? ST_SAT : ST_OK;
			end else begin
				sre_s[0] <= sre_s3;
				sim_s[0] <= sim_s3;
				sst_s[0] <= sst_s3;
			end
			zf_s[0]     <= (op_s3 == OP_DIV) ? (den_s3 == '0) : zf_s3;
			neg_re_s[0] <= neg_re_s3;
			neg_im_s[0] <= neg_im_s3;
			// A quotient of 2^WIDTH or more saturates whatever its fraction.
			ovf_re_s[0] <= {{W{1'b0}}, mag_re_s3[PW-1:W]} >= den_s3;
			ovf_im_s[0] <= {{W{1'b0}}, mag_im_s3[PW-1:W]} >= den_s3;
			den_s[0]    <= den_s3;
			rem_re_s[0] <= {{W{1'b0}}, mag_re_s3[PW-1:W]};
			lo_re_s[0]  <= {mag_re_s3[W-1:0], {(F+1){1'b0}}};
			q_re_s[0]   <= '0;
			rem_im_s[0] <= {{W{1'b0}}, mag_im_s3[PW-1:W]};
			lo_im_s[0]  <= {mag_im_s3[W-1:0], {(F+1){1'b0}}};
			q_im_s[0]   <= '0;
			sqn_s[0]    <= den_s3;
			sqr_s[0]    <= '0;
			cx_s[0]     <= CW'(cx_s3) <<< k_s3;
			cy_s[0]     <= CW'(cy_s3) <<< k_s3;
			cz_s[0]     <= '0;
		end
	end

	// ---------------- iteration stages ----------------
	for (genvar k = 0; k < NSTEP; k++) begin : g_it
		logic [PW-1:0]        n_rem_re, n_rem_im, n_sqn, n_sqr;
		logic [D-1:0]         n_lo_re, n_q_re, n_lo_im, n_q_im;
		logic signed [CW-1:0] n_cx, n_cy;
		logic signed [ZW-1:0] n_cz;

		cau_iter #(
			.WIDTH    (WIDTH),
			.FRAC_BITS(FRAC_BITS),
			.STEP     (k)
		) u_iter (
			.den       (den_s[k]),
			.rem_re    (rem_re_s[k]),
			.lo_re     (lo_re_s[k]),
			.q_re      (q_re_s[k]),
			.rem_im    (rem_im_s[k]),
			.lo_im     (lo_im_s[k]),
			.q_im      (q_im_s[k]),
			.sqn       (sqn_s[k]),
			.sqr       (sqr_s[k]),
			.cx        (cx_s[k]),
			.cy        (cy_s[k]),
			.cz        (cz_s[k]),
			.nxt_rem_re(n_rem_re),
			.nxt_lo_re (n_lo_re),
			.nxt_q_re  (n_q_re),
			.nxt_rem_im(n_rem_im),
			.nxt_lo_im (n_lo_im),
			.nxt_q_im  (n_q_im),
			.nxt_sqn   (n_sqn),
			.nxt_sqr   (n_sqr),
			.nxt_cx    (n_cx),
			.nxt_cy    (n_cy),
			.nxt_cz    (n_cz)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en_s[k+1]) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[k+1]) begin
				op_s[k+1]     <= op_s[k];
				sre_s[k+1]    <= sre_s[k];
				sim_s[k+1]    <= sim_s[k];
				sst_s[k+1]    <= sst_s[k];
				zf_s[k+1]     <= zf_s[k];
				neg_re_s[k+1] <= neg_re_s[k];
				neg_im_s[k+1] <= neg_im_s[k];
				ovf_re_s[k+1] <= ovf_re_s[k];
				ovf_im_s[k+1] <= ovf_im_s[k];
				den_s[k+1]    <= den_s[k];
				rem_re_s[k+1] <= n_rem_re;
				lo_re_s[k+1]  <= n_lo_re;
				q_re_s[k+1]   <= n_q_re;
				rem_im_s[k+1] <= n_rem_im;
				lo_im_s[k+1]  <= n_lo_im;
				q_im_s[k+1]   <= n_q_im;
				sqn_s[k+1]    <= n_sqn;
				sqr_s[k+1]    <= n_sqr;
				cx_s[k+1]     <= n_cx;
				cy_s[k+1]     <= n_cy;
				cz_s[k+1]     <= n_cz;
			end
		end
	end

	// ---------------- output stage ----------------
	logic [D:0]      dq_re, dq_im;
	logic [W:0]      div_re, div_im, mag_o, ph_o;
	logic [PW-1:0]   sq_rnd;
	logic [ZW-1:0]   z_abs;
	logic [ZW:0]     z_rnd;
	logic [W-1:0]    res_re, res_im;
	logic [ST_W-1:0] res_st;

	assign dq_re  = ({1'b0, q_re_s[NSTEP]} + (D+1)'(1)) >> 1;
	assign dq_im  = ({1'b0, q_im_s[NSTEP]} + (D+1)'(1)) >> 1;
	assign div_re = settle(neg_re_s[NSTEP], ovf_re_s[NSTEP] ? '1 : SW'(dq_re));
	assign div_im = settle(neg_im_s[NSTEP], ovf_im_s[NSTEP] ? '1 : SW'(dq_im));

	assign sq_rnd = (sqn_s[NSTEP] > sqr_s[NSTEP]) ? sqr_s[NSTEP] + PW'(1) : sqr_s[NSTEP];
	assign mag_o  = settle(1'b0, SW'(sq_rnd));

	assign z_abs = cz_s[NSTEP][ZW-1] ? -cz_s[NSTEP] : cz_s[NSTEP];
	assign z_rnd = ({1'b0, z_abs} + (ZW+1)'(1 << (ZSH - 1))) >> ZSH;
	assign ph_o  = settle(cz_s[NSTEP][ZW-1], SW'(z_rnd));

	always_comb begin
		res_re = sre_s[NSTEP];
		res_im = sim_s[NSTEP];
		res_st = sst_s[NSTEP];
		case (op_s[NSTEP])
			OP_DIV: begin
				if (zf_s[NSTEP]) begin
					res_re = '0;
					res_im = '0;
					res_st = ST_DIV0;
				end else begin
					res_re = div_re[W-1:0];
					res_im = div_im[W-1:0];
					res_st = (div_re[W] || div_im[W]) ? ST_SAT : ST_OK;
				end
			end
			OP_MAG: begin
				res_re = mag_o[W-1:0];
				res_im = '0;
				res_st = mag_o[W] ? ST_SAT : ST_OK;
			end
			OP_PHASE: begin
				res_im = '0;
				if (zf_s[NSTEP]) begin
					res_re = '0;
					res_st = ST_DIV0;
				end else begin
					res_re = ph_o[W-1:0];
					res_st = ph_o[W] ? ST_SAT : ST_OK;
				end
			end
			default: begin
				res_re = sre_s[NSTEP];
				res_im = sim_s[NSTEP];
				res_st = sst_s[NSTEP];
			end
		endcase
	end

	logic [W-1:0]    ore_q, oim_q;
	logic [ST_W-1:0] ost_q;

	always_ff @(posedge clk) begin
		if (en_o) begin
			ore_q <= res_re;
			oim_q <= res_im;
			ost_q <= res_st;
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = OUT_DW'({oim_q, ore_q});
	assign m_axis_tuser  = ost_q;

endmodule

[hdl/cau_iter.sv]
module cau_iter
	import cau_pkg::*;
#(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 12,
	parameter int STEP      = 0
) (
	input  logic [2*WIDTH-1:0]           den,
	input  logic [2*WIDTH-1:0]           rem_re,
	input  logic [WIDTH+FRAC_BITS:0]     lo_re,
	input  logic [WIDTH+FRAC_BITS:0]     q_re,
	input  logic [2*WIDTH-1:0]           rem_im,
	input  logic [WIDTH+FRAC_BITS:0]     lo_im,
	input  logic [WIDTH+FRAC_BITS:0]     q_im,
	input  logic [2*WIDTH-1:0]           sqn,
	input  logic [2*WIDTH-1:0]           sqr,
	input  logic signed [CW-1:0]         cx,
	input  logic signed [CW-1:0]         cy,
	input  logic signed [ZW-1:0]         cz,
	output logic [2*WIDTH-1:0]           nxt_rem_re,
	output logic [WIDTH+FRAC_BITS:0]     nxt_lo_re,
	output logic [WIDTH+FRAC_BITS:0]     nxt_q_re,
	output logic [2*WIDTH-1:0]           nxt_rem_im,
	output logic [WIDTH+FRAC_BITS:0]     nxt_lo_im,
	output logic [WIDTH+FRAC_BITS:0]     nxt_q_im,
	output logic [2*WIDTH-1:0]           nxt_sqn,
	output logic [2*WIDTH-1:0]           nxt_sqr,
	output logic signed [CW-1:0]         nxt_cx,
	output logic signed [CW-1:0]         nxt_cy,
	output logic signed [ZW-1:0]         nxt_cz
);

	localparam int PW = 2 * WIDTH;
	localparam int D  = WIDTH + FRAC_BITS + 1;
	localparam bit DO_DIV = (STEP < D);
	localparam bit DO_SQ  = (STEP < WIDTH);
	localparam bit DO_COR = (STEP < CORDIC_STEPS);
	localparam int SQ_POS = DO_SQ ? (PW - 2 - 2 * STEP) : 0;
	localparam int COR_SH = DO_COR ? STEP : 0;
	localparam logic [PW-1:0] SQ_BIT = PW'(1) << SQ_POS;
	localparam logic signed [ZW-1:0] ANGLE = cordic_angle(COR_SH);

	// One restoring division step: bring down the next dividend bit.
	function automatic void div_step(
		input  logic [PW-1:0] r,
		input  logic [D-1:0]  l,
		input  logic [D-1:0]  q,
		input  logic [PW-1:0] d,
		output logic [PW-1:0] nr,
		output logic [D-1:0]  nl,
		output logic [D-1:0]  nq
	);
		logic [PW-1:0] t;
		t  = {r[PW-2:0], l[D-1]};
		nl = {l[D-2:0], 1'b0};
		if (t >= d) begin
			nr = t - d;
			nq = {q[D-2:0], 1'b1};
		end else begin
			nr = t;
			nq = {q[D-2:0], 1'b0};
		end
	endfunction

	always_comb begin
		if (DO_DIV) begin
			div_step(rem_re, lo_re, q_re, den, nxt_rem_re, nxt_lo_re, nxt_q_re);
			div_step(rem_im, lo_im, q_im, den, nxt_rem_im, nxt_lo_im, nxt_q_im);
		end else begin
			nxt_rem_re = rem_re;
			nxt_lo_re  = lo_re;
			nxt_q_re   = q_re;
			nxt_rem_im = rem_im;
			nxt_lo_im  = lo_im;
			nxt_q_im   = q_im;
		end
	end

	logic [PW-1:0] sq_try;
	assign sq_try = sqr + SQ_BIT;

	always_comb begin
		nxt_sqn = sqn;
		nxt_sqr = sqr;
		if (DO_SQ) begin
			if (sqn >= sq_try) begin
				nxt_sqn = sqn - sq_try;
				nxt_sqr = (sqr >> 1) + SQ_BIT;
			end else begin
				nxt_sqr = sqr >> 1;
			end
		end
	end

	logic signed [CW-1:0] dx, dy;
	assign dx = cy >>> COR_SH;
	assign dy = cx >>> COR_SH;

	always_comb begin
		nxt_cx = cx;
		nxt_cy = cy;
		nxt_cz = cz;
		if (DO_COR) begin
			if (!cy[CW-1]) begin
				nxt_cx = cx + dx;
				nxt_cy = cy - dy;
				nxt_cz = cz + ANGLE;
			end else begin
				nxt_cx = cx - dx;
				nxt_cy = cy + dy;
				nxt_cz = cz - ANGLE;
			end
		end
	end

endmodule

[hdl/cau_check.sv]
module cau_check
	import cau_pkg::*;
#(
	parameter int WIDTH  = 16,
	parameter int OUT_DW = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_DW-1:0] m_axis_tdata,
	input logic [ST_W-1:0]   m_axis_tuser
);

	localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

	logic [WIDTH-1:0] ore, oim;
	assign ore = m_axis_tdata[WIDTH-1:0];
	assign oim = m_axis_tdata[2*WIDTH-1:WIDTH];

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result word valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result word changed");

	// A zero divisor or a phase of a vector on the imaginary axis gives zero.
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_DIV0 |-> ore == '0 && oim == '0)
		else $error("division by zero with nonzero result");

	// Saturation always leaves at least one part pinned at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_SAT |->
		ore == MAXV || ore == MINV || oim == MAXV || oim == MINV)
		else $error("saturation flagged without a limit value");

endmodule

bind complex_arithmetic_unit cau_check #(
	.WIDTH (WIDTH),
	.OUT_DW(OUT_DW)
) u_cau_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

[tb/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam int W  = 16;
	localparam int FB = 12;
	localparam logic [REQ_W-1:0] OP_NONE = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]    op;
		logic signed [W-1:0] a_re;
		logic signed [W-1:0] a_im;
		logic signed [W-1:0] b_re;
		logic signed [W-1:0] b_im;
	} cplx_req_t;

	typedef struct packed {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		logic [ST_W-1:0]     st;
	} cplx_res_t;

	localparam longint ATAN_TAB [10] = '{843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437, 4194283, 2097149};

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata;
	logic [REQ_W-1:0] s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [31:0]   m_axis_tdata;
	logic [ST_W-1:0] m_axis_tuser;

	cplx_req_t pending_reqs [$];
	cplx_res_t expected_results [$];
	cplx_req_t cur_req;
	int        mismatches;
	int        tx_gap, rx_gap, rx_hold;
	bit        tx_pause, quiet;
	bit        tx_acc;

	complex_arithmetic_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic longint settle(bit neg, longint unsigned mag, inout logic [ST_W-1:0] st);
		longint unsigned lim;
		lim = (64'd1 << (W - 1)) - (neg ? 64'd0 : 64'd1);
		if (mag > lim) begin
			mag = lim;
			st = ST_SAT;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clamp(longint v, inout logic [ST_W-1:0] st);
		return settle(v < 0, v < 0 ? -v : v, st);
	endfunction

	function automatic longint round_shift(longint v, int sh, inout logic [ST_W-1:0] st);
		longint unsigned mag;
		mag = v < 0 ? -v : v;
		return settle(v < 0, (mag + (64'd1 << (sh - 1))) >> sh, st);
	endfunction

	// Bit-serial restoring division, one extra bit for rounding.
	function automatic longint divide_part(longint v, longint unsigned den,
			inout logic [ST_W-1:0] st);
		longint unsigned num, q, rem;
		num = v < 0 ? -v : v;
		q = num / den;
		rem = num % den;
		if (q > (64'd1 << (W - 1)))
			return settle(v < 0, q, st);
		for (int i = 0; i < FB + 1; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 64'd1;
			end
		end
		return settle(v < 0, (q + 64'd1) >> 1, st);
	endfunction

	function automatic longint unsigned sqrt_rounded(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return (n > r) ? r + 64'd1 : r;
	endfunction

	function automatic longint cordic_phase(longint x, longint y, inout logic [ST_W-1:0] st);
		longint z, t, dx, dy, ay;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
		end
		ay = y < 0 ? -y : y;
		while (x < (64'sd1 <<< 40) && ay < (64'sd1 <<< 40)) begin
			x = x * 2;
			y = y * 2;
			ay = ay * 2;
		end
		for (int i = 0; i < 31; i++) begin
			t = i < 10 ? ATAN_TAB[i] : (64'sd1 <<< (30 - i));
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + t;
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - t;
			end
		end
		return round_shift(z, 30 - FB, st);
	endfunction

	function automatic cplx_res_t complex_result(cplx_req_t r);
		cplx_res_t o;
		longint ar, ai, br, bi, re, im;
		longint unsigned den;
		logic [ST_W-1:0] st;
		ar = r.a_re;
		ai = r.a_im;
		br = r.b_re;
		bi = r.b_im;
		re = 0;
		im = 0;
		st = ST_OK;
		case (r.op)
			OP_ADD: begin
				re = clamp(ar + br, st);
				im = clamp(ai + bi, st);
			end
			OP_SUB: begin
				re = clamp(ar - br, st);
				im = clamp(ai - bi, st);
			end
			OP_MUL: begin
				re = round_shift(ar * br - ai * bi, FB, st);
				im = round_shift(ar * bi + br * ai, FB, st);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					st = ST_DIV0;
				end else begin
					re = divide_part(ar * br + ai * bi, den, st);
					im = divide_part(ai * br - ar * bi, den, st);
				end
			end
			OP_CONJ: begin
				re = ar;
				im = clamp(-ai, st);
			end
			OP_MAG: begin
				re = settle(1'b0, sqrt_rounded(ar * ar + ai * ai), st);
			end
			OP_PHASE: begin
				if (ar == 0)
					st = ST_DIV0;
				else
					re = cordic_phase(ar, ai, st);
			end
			default: ;
		endcase
		o.re = re[W-1:0];
		o.im = im[W-1:0];
		o.st = st;
		return o;
	endfunction

	function automatic logic signed [W-1:0] rand_part();
		case ($urandom_range(0, 5))
			0: return W'(16'sh7fff - $urandom_range(0, 3));
			1: return W'(16'sh8000 + $urandom_range(0, 3));
			2: return W'($urandom_range(0, 8191) - 4096);
			3: return '0;
			default: return W'($urandom());
		endcase
	endfunction

	task automatic queue_req(logic [REQ_W-1:0] op, logic signed [W-1:0] ar, ai, br, bi);
		cplx_req_t r;
		r.op = op;
		r.a_re = ar;
		r.a_im = ai;
		r.b_re = br;
		r.b_im = bi;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(int n);
		logic [REQ_W-1:0] op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 40) == 0) ? OP_NONE : REQ_W'($urandom_range(0, 6));
			queue_req(op, rand_part(), rand_part(), rand_part(), rand_part());
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Sender: a new word goes out once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || tx_acc)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (tx_pause || pending_reqs.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				s_axis_tdata <= {cur_req.b_im, cur_req.b_re, cur_req.a_im, cur_req.a_re};
				s_axis_tuser <= cur_req.op;
				s_axis_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					tx_gap = $urandom_range(1, 9);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					rx_gap = $urandom_range(1, 9);
			end
		end
	end

	always @(posedge clk) begin
		cplx_res_t want, got;
		if (arst_n) begin
			tx_acc <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				got.re = m_axis_tdata[15:0];
				got.im = m_axis_tdata[31:16];
				got.st = m_axis_tuser;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word re=%0d im=%0d st=%0d",
							got.re, got.im, got.st);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp re=%0d im=%0d st=%0d got re=%0d im=%0d st=%0d",
								want.re, want.im, want.st, got.re, got.im, got.st);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(complex_result(cur_req));
		end
	end

	initial begin
		#1_000_000;
		$display("tb_complex_arithmetic_unit: errors");
		$finish;
	end

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ADD;
		m_axis_tready = 0;
		mismatches = 0;
		tx_gap = 0;
		rx_gap = 0;
		rx_hold = 0;
		tx_pause = 0;
		quiet = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		queue_req(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		queue_req(OP_ADD, 16'sh1000, -16'sh1000, 16'sh0800, 16'sh0001);
		queue_req(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, 16'sh8000);
		queue_req(OP_SUB, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		queue_req(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		queue_req(OP_MUL, 16'sh1000, 16'sh2000, -16'sh3000, 16'sh0800);
		queue_req(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
		queue_req(OP_DIV, 16'sh1000, 16'sh1000, '0, '0);
		queue_req(OP_DIV, 16'sh7fff, 16'sh8000, '0, 16'sd1);
		queue_req(OP_DIV, 16'sh1000, 16'sh2000, 16'sh1000, -16'sh1000);
		queue_req(OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		queue_req(OP_CONJ, 16'sh8000, 16'sh8000, '0, '0);
		queue_req(OP_CONJ, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		queue_req(OP_MAG, 16'sh8000, 16'sh8000, '0, '0);
		queue_req(OP_MAG, '0, '0, 16'sh8000, 16'sh8000);
		queue_req(OP_MAG, 16'sh3000, -16'sh4000, '0, '0);
		queue_req(OP_PHASE, '0, 16'sh1000, '0, '0);
		queue_req(OP_PHASE, 16'sh1000, 16'sh1000, '0, '0);
		queue_req(OP_PHASE, -16'sh1000, 16'sh1000, '0, '0);
		queue_req(OP_PHASE, 16'sd1, 16'sh7fff, '0, '0);
		queue_req(OP_PHASE, 16'sh8000, 16'sh8000, '0, '0);
		queue_req(OP_PHASE, 16'sh7fff, '0, '0, '0);
		queue_req(OP_NONE, 16'sh7fff, 16'sh8000, 16'sh1234, 16'sh5678);
		drain();

		// Receiver holds off long enough for the pipeline to fill and back up.
		queue_random(500);
		rx_hold = 300;
		while (pending_reqs.size() > 250)
			@(posedge clk);
		tx_pause = 1;
		while (s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		tx_pause = 0;
		drain();

		queue_random(400);
		drain();

		quiet = 1;
		queue_random(200);
		drain();
		repeat (60) @(posedge clk);

		if (mismatches == 0)
			$display("tb_complex_arithmetic_unit: clean");
		else
			$display("tb_complex_arithmetic_unit: errors");
		$finish;
	end

endmodule
